FILE: rtl/core/tsu_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tsu_pkg
// Shared constants, command/status types and fixed-point helpers of the
// tridiagonal solver unit.
// ----------------------------------------------------------------------------
package tsu_pkg;

   localparam int MAX_ORDER = 64;
   localparam int FRAC_BITS = 16;
   localparam int DATA_W    = 32;
   localparam int IDX_W     = $clog2(MAX_ORDER);
   localparam int CNT_W     = $clog2(MAX_ORDER + 1);
   localparam int ORDER_W   = 7;
   localparam int FLOOR_W   = 31;
   localparam int CSR_IDX_W = 2;
   localparam int CSR_DATA_W = 31;
   localparam int QUO_W     = DATA_W + FRAC_BITS;

   localparam logic [CSR_IDX_W-1:0] CSR_ORDER       = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_PIVOT_FLOOR = 2'd1;

   typedef enum logic [3:0] {
      OP_NONE,
      OP_LOAD,
      OP_DIV_SUP,
      OP_DIV_RHS,
      OP_FWD_SUP,
      OP_FWD_DIA,
      OP_FWD_RHS,
      OP_FWD_R,
      OP_BACK_X,
      OP_BACK_MUL,
      OP_BACK_SUB,
      OP_EMIT,
      OP_EMIT_ZERO
   } op_type;

   typedef struct packed {
      op_type           op;
      logic [IDX_W-1:0] addr_a;
      logic [IDX_W-1:0] addr_b;
   } cmd_type;

   typedef struct packed {
      logic div_done;
      logic pivot_bad;
   } stat_type;

   // Product shifted by FRAC_BITS, magnitude truncated, then saturated.
   function automatic logic signed [DATA_W-1:0] fx_mul(input logic signed [DATA_W-1:0] a,
                                                      input logic signed [DATA_W-1:0] b);
      logic signed [2*DATA_W-1:0] p;
      logic [2*DATA_W-1:0] m;
      logic [2*DATA_W-1:0] r;
      logic [DATA_W-1:0] res;
      p = a * b;
      m = p[2*DATA_W-1] ? (~p + 1'b1) : p;
      r = m >> FRAC_BITS;
      if (!p[2*DATA_W-1]) begin
         if (|r[2*DATA_W-1:DATA_W-1]) res = {1'b0, {(DATA_W-1){1'b1}}};
         else res = r[DATA_W-1:0];
      end else begin
         if ((|r[2*DATA_W-1:DATA_W]) || (r[DATA_W-1] && (|r[DATA_W-2:0])))
            res = {1'b1, {(DATA_W-1){1'b0}}};
         else res = ~r[DATA_W-1:0] + 1'b1;
      end
      return res;
   endfunction

   function automatic logic signed [DATA_W-1:0] sat_sub(input logic signed [DATA_W-1:0] a,
                                                       input logic signed [DATA_W-1:0] b);
      logic [DATA_W:0] d;
      logic [DATA_W-1:0] res;
      d = {a[DATA_W-1], a} - {b[DATA_W-1], b};
      if (d[DATA_W] != d[DATA_W-1])
         res = d[DATA_W] ? {1'b1, {(DATA_W-1){1'b0}}} : {1'b0, {(DATA_W-1){1'b1}}};
      else res = d[DATA_W-1:0];
      return res;
   endfunction

endpackage

FILE: rtl/core/tridiagonal_solver_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tridiagonal_solver_unit
// Thomas-algorithm tridiagonal solver, signed Q16.16 with saturation.
//
//   channel  direction  handshake          payload
//   req      in         req_valid/stall    sub, diag, super diagonal, right side
//   rsp      out        rsp_valid/stall    solution, row index, status, last
//   csr      in         csr_write          csr_index, csr_data
//
// Rows load one per cycle. After the last row the solve runs forward
// elimination and back substitution, each division on the single shared
// radix-2 divider. Each result is held until it is taken.
// Requests stall from the last row until the final result is taken.
// Reset is synchronous and clears control state; row stores are not cleared.
// ----------------------------------------------------------------------------
module tridiagonal_solver_unit (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_valid,
   output logic                                 req_stall,
   input  logic signed [tsu_pkg::DATA_W-1:0]    req_sub_diagonal,
   input  logic signed [tsu_pkg::DATA_W-1:0]    req_diagonal,
   input  logic signed [tsu_pkg::DATA_W-1:0]    req_super_diagonal,
   input  logic signed [tsu_pkg::DATA_W-1:0]    req_right_side,
   output logic                                 rsp_valid,
   input  logic                                 rsp_stall,
   output logic signed [tsu_pkg::DATA_W-1:0]    rsp_solution,
   output logic [tsu_pkg::IDX_W-1:0]            rsp_row_index,
   output logic                                 rsp_status,
   output logic                                 rsp_last,
   input  logic                                 csr_write,
   input  logic [tsu_pkg::CSR_IDX_W-1:0]        csr_index,
   input  logic [tsu_pkg::CSR_DATA_W-1:0]       csr_data
);

   tsu_pkg::cmd_type  cmd;
   tsu_pkg::stat_type stat;

   tsu_ctrl u_ctrl (
      .clock         (clock),
      .reset         (reset),
      .csr_write     (csr_write),
      .csr_index     (csr_index),
      .csr_data      (csr_data),
      .req_valid     (req_valid),
      .req_stall     (req_stall),
      .rsp_valid     (rsp_valid),
      .rsp_stall     (rsp_stall),
      .rsp_row_index (rsp_row_index),
      .rsp_status    (rsp_status),
      .rsp_last      (rsp_last),
      .cmd           (cmd),
      .stat          (stat)
   );

   tsu_datapath u_datapath (
      .clock              (clock),
      .reset              (reset),
      .cmd                (cmd),
      .stat               (stat),
      .csr_write          (csr_write),
      .csr_index          (csr_index),
      .csr_data           (csr_data),
      .req_sub_diagonal   (req_sub_diagonal),
      .req_diagonal       (req_diagonal),
      .req_super_diagonal (req_super_diagonal),
      .req_right_side     (req_right_side),
      .rsp_solution       (rsp_solution)
   );

endmodule

FILE: rtl/core/tsu_div.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tsu_div
// Radix-2 restoring divider: (|num| << FRAC_BITS) / |den|, signed result
// truncated toward zero and saturated, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module tsu_div (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              start,
   input  logic signed [tsu_pkg::DATA_W-1:0] num,
   input  logic signed [tsu_pkg::DATA_W-1:0] den,
   output logic                              done,
   output logic signed [tsu_pkg::DATA_W-1:0] quot
);

   localparam int W  = tsu_pkg::DATA_W;
   localparam int QW = tsu_pkg::QUO_W;
   localparam int CW = $clog2(QW + 1);

   logic          busy_ff, busy_in;
   logic          done_ff, done_in;
   logic [CW-1:0] cnt_ff, cnt_in;
   logic          neg_ff, neg_in;
   logic [W-1:0]  den_ff, den_in;
   logic [W-1:0]  rem_ff, rem_in;
   logic [QW-1:0] quo_ff, quo_in;
   logic [W-1:0]  res_ff, res_in;
   logic [W:0]    trial;
   logic          ge;
   logic [W-1:0]  num_mag;
   logic [QW-1:0] quo_next;

   always_comb begin
      trial    = {rem_ff, quo_ff[QW-1]};
      ge       = trial >= {1'b0, den_ff};
      quo_next = {quo_ff[QW-2:0], ge};
      num_mag  = num[W-1] ? (~num + 1'b1) : num;
      busy_in  = busy_ff;
      done_in  = 1'b0;
      cnt_in   = cnt_ff;
      neg_in   = neg_ff;
      den_in   = den_ff;
      rem_in   = rem_ff;
      quo_in   = quo_ff;
      res_in   = res_ff;
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = '0;
         neg_in  = num[W-1] ^ den[W-1];
         den_in  = den[W-1] ? (~den + 1'b1) : den;
         rem_in  = '0;
         quo_in  = {num_mag, {tsu_pkg::FRAC_BITS{1'b0}}};
      end else if (busy_ff) begin
         rem_in = ge ? W'(trial - {1'b0, den_ff}) : trial[W-1:0];
         quo_in = quo_next;
         cnt_in = cnt_ff + 1'b1;
         if (cnt_ff == CW'(QW - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
            if (!neg_ff) begin
               if (|quo_next[QW-1:W-1]) res_in = {1'b0, {(W-1){1'b1}}};
               else res_in = quo_next[W-1:0];
            end else begin
               if ((|quo_next[QW-1:W]) || (quo_next[W-1] && (|quo_next[W-2:0])))
                  res_in = {1'b1, {(W-1){1'b0}}};
               else res_in = ~quo_next[W-1:0] + 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      neg_ff <= neg_in;
      den_ff <= den_in;
      rem_ff <= rem_in;
      quo_ff <= quo_in;
      res_ff <= res_in;
   end

   assign done = done_ff;
   assign quot = res_ff;

endmodule

FILE: rtl/core/tsu_datapath.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tsu_datapath
// Row stores, pivot check, shared divider, multiplier and saturating
// subtractor, driven by commands from the controller.
// ----------------------------------------------------------------------------
module tsu_datapath (
   input  logic                                  clock,
   input  logic                                  reset,
   input  tsu_pkg::cmd_type                      cmd,
   output tsu_pkg::stat_type                     stat,
   input  logic                                  csr_write,
   input  logic [tsu_pkg::CSR_IDX_W-1:0]         csr_index,
   input  logic [tsu_pkg::CSR_DATA_W-1:0]        csr_data,
   input  logic signed [tsu_pkg::DATA_W-1:0]     req_sub_diagonal,
   input  logic signed [tsu_pkg::DATA_W-1:0]     req_diagonal,
   input  logic signed [tsu_pkg::DATA_W-1:0]     req_super_diagonal,
   input  logic signed [tsu_pkg::DATA_W-1:0]     req_right_side,
   output logic signed [tsu_pkg::DATA_W-1:0]     rsp_solution
);

   localparam int W = tsu_pkg::DATA_W;

   logic signed [W-1:0] sub_mem [tsu_pkg::MAX_ORDER];
   logic signed [W-1:0] dia_mem [tsu_pkg::MAX_ORDER];
   logic signed [W-1:0] sup_mem [tsu_pkg::MAX_ORDER];
   logic signed [W-1:0] rhs_mem [tsu_pkg::MAX_ORDER];

   logic signed [W-1:0] sub_q, dia_q, sup_q, rhs_q;
   logic signed [W-1:0] cur_d_ff, cur_r_ff, prod_ff, sol_ff;
   logic [tsu_pkg::FLOOR_W-1:0] floor_ff;

   logic                div_start;
   logic signed [W-1:0] div_num;
   logic                div_done;
   logic signed [W-1:0] quot;
   logic [W-1:0]        piv_mag;
   logic signed [W-1:0] diff_d, diff_r;
   logic                sup_we, rhs_we;
   logic signed [W-1:0] sup_wd, rhs_wd;

   tsu_div u_div (
      .clock (clock),
      .reset (reset),
      .start (div_start),
      .num   (div_num),
      .den   (cur_d_ff),
      .done  (div_done),
      .quot  (quot)
   );

   always_comb begin
      div_start = (cmd.op == tsu_pkg::OP_DIV_SUP) || (cmd.op == tsu_pkg::OP_DIV_RHS);
      div_num   = (cmd.op == tsu_pkg::OP_DIV_SUP) ? sup_q : cur_r_ff;
      piv_mag   = cur_d_ff[W-1] ? (~cur_d_ff + 1'b1) : cur_d_ff;
      stat.div_done  = div_done;
      stat.pivot_bad = (piv_mag == '0) || (piv_mag < {1'b0, floor_ff});
      diff_d = tsu_pkg::sat_sub(dia_q, prod_ff);
      diff_r = tsu_pkg::sat_sub(rhs_q, prod_ff);
      sup_we = 1'b0;
      sup_wd = quot;
      rhs_we = 1'b0;
      rhs_wd = quot;
      case (cmd.op)
         tsu_pkg::OP_LOAD: begin
            sup_we = 1'b1;
            sup_wd = req_super_diagonal;
            rhs_we = 1'b1;
            rhs_wd = req_right_side;
         end
         tsu_pkg::OP_FWD_SUP: sup_we = 1'b1;
         tsu_pkg::OP_FWD_RHS, tsu_pkg::OP_BACK_X: rhs_we = 1'b1;
         tsu_pkg::OP_BACK_SUB: begin
            rhs_we = 1'b1;
            rhs_wd = diff_r;
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (cmd.op == tsu_pkg::OP_LOAD) begin
         sub_mem[cmd.addr_a] <= req_sub_diagonal;
         dia_mem[cmd.addr_a] <= req_diagonal;
      end
      if (sup_we) sup_mem[cmd.addr_a] <= sup_wd;
      if (rhs_we) rhs_mem[cmd.addr_a] <= rhs_wd;
      sub_q <= sub_mem[cmd.addr_b];
      dia_q <= dia_mem[cmd.addr_b];
      rhs_q <= rhs_mem[cmd.addr_b];
      sup_q <= sup_mem[cmd.addr_a];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         floor_ff <= tsu_pkg::FLOOR_W'(1);
      end else if (csr_write && (csr_index == tsu_pkg::CSR_PIVOT_FLOOR)) begin
         floor_ff <= csr_data[tsu_pkg::FLOOR_W-1:0];
      end
      case (cmd.op)
         tsu_pkg::OP_LOAD: begin
            // row 0 seeds the running pivot and right side
            if (cmd.addr_a == '0) begin
               cur_d_ff <= req_diagonal;
               cur_r_ff <= req_right_side;
            end
         end
         tsu_pkg::OP_FWD_SUP, tsu_pkg::OP_FWD_RHS: prod_ff <= tsu_pkg::fx_mul(sub_q, quot);
         tsu_pkg::OP_FWD_DIA: cur_d_ff <= diff_d;
         tsu_pkg::OP_FWD_R:   cur_r_ff <= diff_r;
         tsu_pkg::OP_BACK_X:  cur_r_ff <= quot;
         tsu_pkg::OP_BACK_MUL: prod_ff <= tsu_pkg::fx_mul(sup_q, cur_r_ff);
         tsu_pkg::OP_BACK_SUB: cur_r_ff <= diff_r;
         tsu_pkg::OP_EMIT:      sol_ff <= rhs_q;
         tsu_pkg::OP_EMIT_ZERO: sol_ff <= '0;
         default: ;
      endcase
   end

   assign rsp_solution = sol_ff;

endmodule

FILE: rtl/core/tsu_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tsu_ctrl
// Sequencer: row loading, forward elimination, back substitution and
// result emission, plus the order register.
// ----------------------------------------------------------------------------
module tsu_ctrl (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           csr_write,
   input  logic [tsu_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [tsu_pkg::CSR_DATA_W-1:0] csr_data,
   input  logic                           req_valid,
   output logic                           req_stall,
   output logic                           rsp_valid,
   input  logic                           rsp_stall,
   output logic [tsu_pkg::IDX_W-1:0]      rsp_row_index,
   output logic                           rsp_status,
   output logic                           rsp_last,
   output tsu_pkg::cmd_type               cmd,
   input  tsu_pkg::stat_type              stat
);

   localparam int IW = tsu_pkg::IDX_W;
   localparam int CW = tsu_pkg::CNT_W;

   typedef enum logic [4:0] {
      S_LOAD, S_F_CHK, S_F_DIV_SUP, S_F_WAIT_SUP, S_F_MUL_SUP, S_F_SUB_DIA,
      S_F_DIV_RHS, S_F_WAIT_RHS, S_F_MUL_RHS, S_F_SUB_RHS,
      S_B_CHK, S_B_DIV, S_B_WAIT, S_B_X, S_B_RD, S_B_MUL, S_B_SUB,
      S_O_RD, S_O_EMIT, S_O_HOLD
   } state_type;

   state_type                   state_ff, state_in;
   logic [IW-1:0]               k_ff, k_in;
   logic [IW-1:0]               rows_ff, rows_in;
   logic [tsu_pkg::ORDER_W-1:0] order_ff, order_in;
   logic                        valid_ff, valid_in;
   logic                        status_ff, status_in;
   logic                        last_ff, last_in;
   logic [CW-1:0]               n;

   always_comb begin
      if (order_ff == '0) n = CW'(1);
      else if (int'(order_ff) > tsu_pkg::MAX_ORDER) n = CW'(tsu_pkg::MAX_ORDER);
      else n = CW'(order_ff);
   end

   always_comb begin
      state_in  = state_ff;
      k_in      = k_ff;
      rows_in   = rows_ff;
      order_in  = order_ff;
      valid_in  = valid_ff;
      status_in = status_ff;
      last_in   = last_ff;
      cmd.op     = tsu_pkg::OP_NONE;
      cmd.addr_a = k_ff;
      cmd.addr_b = k_ff;
      unique case (state_ff)
         S_F_CHK, S_F_DIV_SUP, S_F_WAIT_SUP, S_F_MUL_SUP, S_F_SUB_DIA,
         S_F_DIV_RHS, S_F_WAIT_RHS, S_F_MUL_RHS, S_F_SUB_RHS: cmd.addr_b = k_ff + 1'b1;
         default: ;
      endcase

      unique case (state_ff)
         S_LOAD: begin
            cmd.addr_a = rows_ff;
            if (req_valid) begin
               cmd.op = tsu_pkg::OP_LOAD;
               if (CW'(rows_ff) + CW'(1) == n) begin
                  rows_in  = '0;
                  k_in     = '0;
                  state_in = (n == CW'(1)) ? S_B_CHK : S_F_CHK;
               end else begin
                  rows_in = rows_ff + 1'b1;
               end
            end
         end
         S_F_CHK, S_B_CHK: begin
            if (stat.pivot_bad) begin
               cmd.op    = tsu_pkg::OP_EMIT_ZERO;
               valid_in  = 1'b1;
               status_in = 1'b1;
               last_in   = 1'b1;
               state_in  = S_O_HOLD;
            end else begin
               state_in = (state_ff == S_F_CHK) ? S_F_DIV_SUP : S_B_DIV;
            end
         end
         S_F_DIV_SUP: begin
            cmd.op   = tsu_pkg::OP_DIV_SUP;
            state_in = S_F_WAIT_SUP;
         end
         S_F_WAIT_SUP: if (stat.div_done) state_in = S_F_MUL_SUP;
         S_F_MUL_SUP: begin
            cmd.op   = tsu_pkg::OP_FWD_SUP;
            state_in = S_F_DIV_RHS;
         end
         // start the right side division while the pivot is still current
         S_F_DIV_RHS: begin
            cmd.op   = tsu_pkg::OP_DIV_RHS;
            state_in = S_F_SUB_DIA;
         end
         S_F_SUB_DIA: begin
            cmd.op   = tsu_pkg::OP_FWD_DIA;
            state_in = S_F_WAIT_RHS;
         end
         S_F_WAIT_RHS: if (stat.div_done) state_in = S_F_MUL_RHS;
         S_F_MUL_RHS: begin
            cmd.op   = tsu_pkg::OP_FWD_RHS;
            state_in = S_F_SUB_RHS;
         end
         S_F_SUB_RHS: begin
            cmd.op   = tsu_pkg::OP_FWD_R;
            k_in     = k_ff + 1'b1;
            state_in = (CW'(k_ff) + CW'(2) < n) ? S_F_CHK : S_B_CHK;
         end
         S_B_DIV: begin
            cmd.op   = tsu_pkg::OP_DIV_RHS;
            state_in = S_B_WAIT;
         end
         S_B_WAIT: if (stat.div_done) state_in = S_B_X;
         S_B_X, S_B_SUB: begin
            cmd.op = (state_ff == S_B_X) ? tsu_pkg::OP_BACK_X : tsu_pkg::OP_BACK_SUB;
            if (k_ff == '0) begin
               state_in = S_O_RD;
            end else begin
               k_in     = k_ff - 1'b1;
               state_in = S_B_RD;
            end
         end
         S_B_RD: state_in = S_B_MUL;
         S_B_MUL: begin
            cmd.op   = tsu_pkg::OP_BACK_MUL;
            state_in = S_B_SUB;
         end
         S_O_RD: state_in = S_O_EMIT;
         S_O_EMIT: begin
            cmd.op    = tsu_pkg::OP_EMIT;
            valid_in  = 1'b1;
            status_in = 1'b0;
            last_in   = (CW'(k_ff) + CW'(1) == n);
            state_in  = S_O_HOLD;
         end
         S_O_HOLD: begin
            if (!rsp_stall) begin
               valid_in = 1'b0;
               if (last_ff) begin
                  state_in = S_LOAD;
               end else begin
                  k_in     = k_ff + 1'b1;
                  state_in = S_O_RD;
               end
            end
         end
         default: state_in = S_LOAD;
      endcase

      // an order write discards any partly loaded system
      if (csr_write && (csr_index == tsu_pkg::CSR_ORDER)) begin
         order_in = csr_data[tsu_pkg::ORDER_W-1:0];
         rows_in  = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= S_LOAD;
         k_ff      <= '0;
         rows_ff   <= '0;
         order_ff  <= tsu_pkg::ORDER_W'(1);
         valid_ff  <= 1'b0;
         status_ff <= 1'b0;
         last_ff   <= 1'b0;
      end else begin
         state_ff  <= state_in;
         k_ff      <= k_in;
         rows_ff   <= rows_in;
         order_ff  <= order_in;
         valid_ff  <= valid_in;
         status_ff <= status_in;
         last_ff   <= last_in;
      end
   end

   assign req_stall     = (state_ff != S_LOAD);
   assign rsp_valid     = valid_ff;
   assign rsp_row_index = k_ff;
   assign rsp_status    = status_ff;
   assign rsp_last      = last_ff;

endmodule

FILE: tb/sv/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the tridiagonal solver unit. Rows are driven in
// bursts from a queue, each accepted row is fed to an in-bench Q16.16 Thomas
// solver, and every result is compared in order with the predicted one.
// Directed cases cover field extremes, singular pivots and register corner
// cases; random phases vary order and pivot floor under random stalls.
// ----------------------------------------------------------------------------
module tb_top;

   localparam int DATA_W     = tsu_pkg::DATA_W;
   localparam int IDX_W      = tsu_pkg::IDX_W;
   localparam int ORDER_W    = tsu_pkg::ORDER_W;
   localparam int FLOOR_W    = tsu_pkg::FLOOR_W;
   localparam int CSR_IDX_W  = tsu_pkg::CSR_IDX_W;
   localparam int CSR_DATA_W = tsu_pkg::CSR_DATA_W;
   localparam int MAX_ORDER  = tsu_pkg::MAX_ORDER;
   localparam int FRAC_BITS  = tsu_pkg::FRAC_BITS;
   localparam logic [CSR_IDX_W-1:0] CSR_ORDER       = tsu_pkg::CSR_ORDER;
   localparam logic [CSR_IDX_W-1:0] CSR_PIVOT_FLOOR = tsu_pkg::CSR_PIVOT_FLOOR;

   localparam logic STATUS_SOLVED   = 1'b0;
   localparam logic STATUS_SINGULAR = 1'b1;
   localparam int   SETTLE_CYCLES   = 200;

   typedef struct {
      logic signed [DATA_W-1:0] sub;
      logic signed [DATA_W-1:0] dia;
      logic signed [DATA_W-1:0] sup;
      logic signed [DATA_W-1:0] rhs;
   } system_row_type;

   typedef struct {
      logic signed [DATA_W-1:0] solution;
      logic [IDX_W-1:0]         row_index;
      logic                     status;
      logic                     last;
   } solution_item_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_stall;
   logic signed [DATA_W-1:0] req_sub_diagonal = '0;
   logic signed [DATA_W-1:0] req_diagonal = '0;
   logic signed [DATA_W-1:0] req_super_diagonal = '0;
   logic signed [DATA_W-1:0] req_right_side = '0;
   logic rsp_valid;
   logic rsp_stall = 1'b0;
   logic signed [DATA_W-1:0] rsp_solution;
   logic [IDX_W-1:0] rsp_row_index;
   logic rsp_status;
   logic rsp_last;
   logic csr_write = 1'b0;
   logic [CSR_IDX_W-1:0] csr_index = '0;
   logic [CSR_DATA_W-1:0] csr_data = '0;

   tridiagonal_solver_unit u_top (.*);

   always #4 clock = ~clock;

   // solver shadow state
   logic [ORDER_W-1:0] order_reg = 7'd1;
   logic [FLOOR_W-1:0] floor_reg = 31'd1;
   int sub_st[MAX_ORDER], dia_st[MAX_ORDER], sup_st[MAX_ORDER], rhs_st[MAX_ORDER];
   int rows_loaded = 0;

   system_row_type    pending_rows[$];
   solution_item_type expected_solutions[$];
   system_row_type    cur_row;
   int errors = 0, rows_sent = 0, results_seen = 0, solved_cnt = 0, singular_cnt = 0;
   int burst_left = 0, gap_left = 0, stall_left = 0;
   logic stall_val = 1'b0;

   function automatic int clamp32(longint v);
      if (v > 64'sd2147483647) return 32'sh7FFFFFFF;
      if (v < -64'sd2147483648) return 32'sh80000000;
      return int'(v);
   endfunction

   function automatic int qmul(int a, int b);
      longint p, m;
      p = longint'(a) * longint'(b);
      m = (p < 0) ? -p : p;
      m = m >> FRAC_BITS;
      return clamp32((p < 0) ? -m : m);
   endfunction

   function automatic int qdiv(int num, int den);
      longint n, d, q;
      n = ((num < 0) ? -longint'(num) : longint'(num)) << FRAC_BITS;
      d = (den < 0) ? -longint'(den) : longint'(den);
      if (d == 0) return 0;
      q = n / d;
      return clamp32(((num < 0) != (den < 0)) ? -q : q);
   endfunction

   function automatic int qsub(int a, int b);
      return clamp32(longint'(a) - longint'(b));
   endfunction

   function automatic bit pivot_is_bad(int s);
      longint m;
      m = (s < 0) ? -longint'(s) : longint'(s);
      return (m == 0) || (m < longint'(floor_reg));
   endfunction

   function automatic int eff_order(logic [ORDER_W-1:0] o);
      if (o == 0) return 1;
      if (o > MAX_ORDER) return MAX_ORDER;
      return int'(o);
   endfunction

   task automatic push_singular(int row);
      solution_item_type e;
      e.solution = '0;
      e.row_index = row[IDX_W-1:0];
      e.status = STATUS_SINGULAR;
      e.last = 1'b1;
      expected_solutions.push_back(e);
      singular_cnt++;
   endtask

   task automatic solve_system(int n);
      int sup[MAX_ORDER], dia[MAX_ORDER], rhs[MAX_ORDER];
      solution_item_type e;
      sup = sup_st;
      dia = dia_st;
      rhs = rhs_st;
      for (int k = 0; k + 1 < n; k++) begin
         if (pivot_is_bad(dia[k])) begin
            push_singular(k);
            return;
         end
         sup[k] = qdiv(sup[k], dia[k]);
         rhs[k] = qdiv(rhs[k], dia[k]);
         dia[k+1] = qsub(dia[k+1], qmul(sub_st[k+1], sup[k]));
         rhs[k+1] = qsub(rhs[k+1], qmul(sub_st[k+1], rhs[k]));
      end
      if (pivot_is_bad(dia[n-1])) begin
         push_singular(n - 1);
         return;
      end
      rhs[n-1] = qdiv(rhs[n-1], dia[n-1]);
      for (int k = n - 1; k > 0; k--)
         rhs[k-1] = qsub(rhs[k-1], qmul(sup[k-1], rhs[k]));
      for (int k = 0; k < n; k++) begin
         e.solution = rhs[k];
         e.row_index = k[IDX_W-1:0];
         e.status = STATUS_SOLVED;
         e.last = (k + 1 == n);
         expected_solutions.push_back(e);
      end
      solved_cnt++;
   endtask

   task automatic load_row(system_row_type row);
      int n, r;
      n = eff_order(order_reg);
      r = (rows_loaded >= n) ? 0 : rows_loaded;
      sub_st[r] = row.sub;
      dia_st[r] = row.dia;
      sup_st[r] = row.sup;
      rhs_st[r] = row.rhs;
      rows_loaded = r + 1;
      if (rows_loaded >= n) begin
         rows_loaded = 0;
         solve_system(n);
      end
   endtask

   // request driver: bursts with random gaps, payload held while stalled
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (req_valid && !req_stall) begin
            load_row(cur_row);
            rows_sent++;
         end
         if (req_valid && req_stall) begin
            req_valid <= 1'b1;
         end else if (gap_left > 0) begin
            gap_left--;
            req_valid <= 1'b0;
         end else if (pending_rows.size() != 0) begin
            cur_row = pending_rows.pop_front();
            req_sub_diagonal <= cur_row.sub;
            req_diagonal <= cur_row.dia;
            req_super_diagonal <= cur_row.sup;
            req_right_side <= cur_row.rhs;
            req_valid <= 1'b1;
            if (burst_left > 0) begin
               burst_left--;
            end else begin
               burst_left = $urandom_range(0, 12);
               gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
            end
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   // result stall pattern: random segments, some long quiet stretches
   always @(posedge clock) begin
      if (stall_left == 0) begin
         if ($urandom_range(0, 3) == 0) begin
            stall_val = 1'b0;
            stall_left = $urandom_range(20, 60);
         end else begin
            stall_val = $urandom_range(0, 1);
            stall_left = $urandom_range(1, 10);
         end
      end else begin
         stall_left--;
      end
      rsp_stall <= stall_val;
   end

   // result monitor
   always @(posedge clock) begin
      solution_item_type e;
      if (!reset && rsp_valid && !rsp_stall) begin
         results_seen++;
         if (expected_solutions.size() == 0) begin
            $display("%t: unexpected result solution=%h index=%0d status=%b last=%b", $time,
                     rsp_solution, rsp_row_index, rsp_status, rsp_last);
            errors++;
         end else begin
            e = expected_solutions.pop_front();
            if (rsp_solution !== e.solution) begin
               $display("%t: solution expected %h actual %h", $time, e.solution, rsp_solution);
               errors++;
            end
            if (rsp_row_index !== e.row_index) begin
               $display("%t: row_index expected %0d actual %0d", $time, e.row_index,
                        rsp_row_index);
               errors++;
            end
            if (rsp_status !== e.status) begin
               $display("%t: status expected %b actual %b", $time, e.status, rsp_status);
               errors++;
            end
            if (rsp_last !== e.last) begin
               $display("%t: last expected %b actual %b", $time, e.last, rsp_last);
               errors++;
            end
         end
      end
   end

   task automatic wait_idle();
      while (pending_rows.size() != 0 || req_valid || expected_solutions.size() != 0)
         @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_csr(logic [CSR_IDX_W-1:0] idx, logic [CSR_DATA_W-1:0] val);
      wait_idle();
      @(posedge clock);
      csr_write <= 1'b1;
      csr_index <= idx;
      csr_data <= val;
      if (idx == CSR_ORDER) begin
         order_reg = val[ORDER_W-1:0];
         rows_loaded = 0;
      end else if (idx == CSR_PIVOT_FLOOR) begin
         floor_reg = val;
      end
      @(posedge clock);
      csr_write <= 1'b0;
   endtask

   task automatic add_row(int sub, int dia, int sup, int rhs);
      system_row_type row;
      row.sub = sub;
      row.dia = dia;
      row.sup = sup;
      row.rhs = rhs;
      pending_rows.push_back(row);
   endtask

   // diagonally dominant row, or raw noise
   task automatic add_random_row(bit noisy);
      int mag;
      if (noisy) begin
         add_row($urandom, $urandom, $urandom, $urandom);
      end else begin
         mag = $urandom_range(2 << FRAC_BITS, 16 << FRAC_BITS);
         add_row(int'($urandom_range(0, 2 << FRAC_BITS)) - (1 << FRAC_BITS),
                 $urandom_range(0, 1) ? mag : -mag,
                 int'($urandom_range(0, 2 << FRAC_BITS)) - (1 << FRAC_BITS),
                 int'($urandom_range(0, 200 << FRAC_BITS)) - (100 << FRAC_BITS));
      end
   endtask

   localparam int ONE = 1 << FRAC_BITS;

   initial begin
      int n, systems, big_done, pick;
      bit noisy_sys;
      repeat (4) @(posedge clock);
      reset <= 1'b0;

      // order one at reset: extremes, zero pivot, negative pivot
      add_row(32'sh80000000, 32'sh7FFFFFFF, 32'sh80000000, 32'sh80000000);
      add_row(32'sh7FFFFFFF, 0, 32'sh7FFFFFFF, 32'sh7FFFFFFF);
      add_row(0, -ONE, 0, 3 * ONE);
      // order zero acts as one
      write_csr(CSR_ORDER, 31'd0);
      add_row(0, 32'sh80000000, 0, 32'sh7FFFFFFF);
      // partial load discarded by an order write
      write_csr(CSR_ORDER, 31'd3);
      add_row(ONE, 2 * ONE, ONE, ONE);
      add_row(ONE, 3 * ONE, ONE, ONE);
      write_csr(CSR_ORDER, 31'd2);
      add_row(0, 4 * ONE, ONE, 5 * ONE);
      add_row(-ONE, 3 * ONE, 0, -2 * ONE);
      // out-of-range register indexes are ignored
      write_csr(2'd2, 31'h7FFFFFFF);
      write_csr(2'd3, 31'h0);
      // zero floor still flags a zero pivot
      write_csr(CSR_PIVOT_FLOOR, 31'd0);
      add_row(ONE, 0, ONE, ONE);
      add_row(ONE, ONE, 0, ONE);
      // largest floor makes any pivot smaller in magnitude than 0x7FFFFFFF singular
      write_csr(CSR_PIVOT_FLOOR, 31'h7FFFFFFF);
      add_row(0, 32'sh7FFFFFFF, ONE, ONE);
      add_row(ONE, 2 * ONE, 0, ONE);
      // floor write mid-load leaves the load intact
      write_csr(CSR_PIVOT_FLOOR, 31'd1);
      write_csr(CSR_ORDER, 31'd3);
      add_row(0, 5 * ONE, ONE, ONE);
      wait_idle();
      write_csr(CSR_PIVOT_FLOOR, 31'd1);
      add_row(ONE, 5 * ONE, ONE, 2 * ONE);
      add_row(ONE, 5 * ONE, 0, 3 * ONE);
      // second pivot eliminated to zero
      write_csr(CSR_ORDER, 31'd2);
      add_row(0, ONE, ONE, ONE);
      add_row(ONE, ONE, 0, ONE);

      big_done = 0;
      while (rows_sent + pending_rows.size() < 310) begin
         pick = $urandom_range(0, 19);
         if (pick == 0 && big_done < 2) begin
            write_csr(CSR_ORDER, big_done ? 31'd127 : 31'd64);
            big_done++;
            systems = 1;
         end else begin
            write_csr(CSR_ORDER, (pick < 17) ? 31'($urandom_range(1, 6)) :
                      31'($urandom_range(7, 16)));
            systems = $urandom_range(1, 4);
         end
         pick = $urandom_range(0, 9);
         write_csr(CSR_PIVOT_FLOOR, (pick < 6) ? 31'd1 : (pick == 6) ? 31'd0 :
                   (pick == 7) ? 31'h7FFFFFFF : 31'($urandom_range(0, 4 << FRAC_BITS)));
         n = eff_order(order_reg);
         repeat (systems) begin
            noisy_sys = ($urandom_range(0, 6) == 0);
            for (int k = 0; k < n; k++)
               add_random_row(noisy_sys || ($urandom_range(0, 19) == 0));
         end
      end

      wait_idle();
      $display("Covered %0d rows, %0d results: %0d systems solved, %0d singular.",
               rows_sent, results_seen, solved_cnt, singular_cnt);
      if (errors == 0) begin
         $display("Simulation PASSED");
      end else begin
         $display("Simulation FAILED");
      end
      $finish;
   end

   initial begin
      #5_000_000;
      $display("Simulation FAILED");
      $finish;
   end

endmodule
